>>> rtl/scdp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sampled column dot product core.
package scdp_pkg;

    localparam logic [1:0] ACT_WR_U  = 2'd0;
    localparam logic [1:0] ACT_WR_V  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam int DOT_W   = 64;
    localparam int ELEM_W  = 32;
    localparam int RANK_W  = 6;
    localparam logic [RANK_W-1:0] RANK_RESET = 6'd32;

    localparam logic signed [DOT_W-1:0] DOT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [DOT_W-1:0] DOT_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]               action;
        logic [9:0]               col_a;
        logic [9:0]               col_b;
        logic [4:0]               element_index;
        logic signed [ELEM_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot_product;
        logic                    saturated;
        logic                    index_error;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic wr_u;
        logic wr_v;
        logic query_start;
        logic acc_clr;
        logic rd_en;
        logic ld_err;
        logic ld_sum;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic wr_err;
        logic q_err;
        logic pipe_busy;
    } t_sts;

endpackage

>>> rtl/scdp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module scdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/scdp_ctrl.sv
`timescale 1ns / 1ps
// Controller: item decode, row sequencing, rank register and result strobe.
module scdp_ctrl
    import scdp_pkg::*;
#(
    parameter int MAX_RANK = 32,
    parameter int ROW_W    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_action,
    input  logic              i_cfg_we,
    input  logic [RANK_W-1:0] i_cfg_wdata,
    input  t_sts              i_sts,
    output t_cmd              o_cmd,
    output logic [ROW_W-1:0]  o_rd_row,
    output logic              o_busy,
    output logic              o_strobe
);

    localparam int CNT_W = $clog2(MAX_RANK + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [RANK_W-1:0] r_rank;
    logic              r_busy, r_strobe;
    logic [CNT_W-1:0]  rank_eff;
    logic              accept;
    t_cmd              cmd;

    // rank above MAX_RANK is clamped
    assign rank_eff = (32'(r_rank) > MAX_RANK) ? CNT_W'(MAX_RANK) : CNT_W'(r_rank);
    assign accept   = i_start && !r_busy;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_WR_U: begin
                            if (i_sts.wr_err) cmd.ld_err = 1'b1;
                            else              cmd.wr_u   = 1'b1;
                        end
                        ACT_WR_V: begin
                            if (i_sts.wr_err) cmd.ld_err = 1'b1;
                            else              cmd.wr_v   = 1'b1;
                        end
                        ACT_QUERY: begin
                            if (i_sts.q_err) begin
                                cmd.ld_err = 1'b1;
                            end else begin
                                cmd.query_start = 1'b1;
                                cmd.acc_clr     = 1'b1;
                                n_k             = '0;
                                n_state         = S_READ;
                            end
                        end
                        default: ;  // undefined action: dropped
                    endcase
                end
            end
            S_READ: begin
                if (r_k < rank_eff) begin
                    cmd.rd_en = 1'b1;
                    n_k       = r_k + 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    cmd.ld_sum = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= '0;
            r_rank   <= RANK_RESET;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_busy   <= (n_state != S_IDLE);
            r_strobe <= cmd.ld_err || cmd.ld_sum;
            if (i_cfg_we) begin
                r_rank <= i_cfg_wdata;
            end
        end
    end

    assign o_cmd    = cmd;
    assign o_rd_row = r_k[ROW_W-1:0];
    assign o_busy   = r_busy;
    assign o_strobe = r_strobe;

endmodule

>>> rtl/scdp_dp.sv
`timescale 1ns / 1ps
// Datapath: factor stores, range checks, multiply, wide accumulate, clamp.
module scdp_dp
    import scdp_pkg::*;
#(
    parameter int MAX_RANK    = 32,
    parameter int MAX_COLUMNS = 1024,
    parameter int ROW_W       = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_item            i_item,
    input  t_cmd             i_cmd,
    input  logic [ROW_W-1:0] i_rd_row,
    output t_sts             o_sts,
    output t_result          o_result
);

    localparam int DEPTH = MAX_RANK * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W = 2 * ELEM_W + 1 + $clog2(MAX_RANK);

    logic [AW-1:0]            wr_addr, rd_addr;
    logic [AW-1:0]            r_base_a, r_base_b;
    logic [ELEM_W-1:0]        u_rdata, v_rdata;
    logic                     r_rd_vld, r_prod_vld;
    logic signed [DOT_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    t_result                  r_res;
    logic                     fits;
    logic                     col_a_bad, col_b_bad, row_bad;

    assign col_a_bad = 32'(i_item.col_a) >= MAX_COLUMNS;
    assign col_b_bad = 32'(i_item.col_b) >= MAX_COLUMNS;
    assign row_bad   = 32'(i_item.element_index) >= MAX_RANK;

    assign o_sts.wr_err    = col_a_bad || row_bad;
    assign o_sts.q_err     = col_a_bad || col_b_bad;
    assign o_sts.pipe_busy = r_rd_vld || r_prod_vld;

    // element address = column * MAX_RANK + row; only used once in range
    assign wr_addr = AW'(AW'(i_item.col_a) * AW'(MAX_RANK)
                         + AW'(i_item.element_index));
    assign rd_addr = AW'(i_rd_row);

    logic [AW-1:0] rd_addr_u, rd_addr_v;
    assign rd_addr_u = r_base_a + rd_addr;
    assign rd_addr_v = r_base_b + rd_addr;

    scdp_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_u),
        .i_waddr(wr_addr),
        .i_wdata(i_item.value),
        .i_re   (i_cmd.rd_en),
        .i_raddr(rd_addr_u),
        .o_rdata(u_rdata)
    );

    scdp_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) v_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_v),
        .i_waddr(wr_addr),
        .i_wdata(i_item.value),
        .i_re   (i_cmd.rd_en),
        .i_raddr(rd_addr_v),
        .o_rdata(v_rdata)
    );

    // sum fits in Q32.32 when all bits above bit 63 equal the sign
    assign fits = (&r_acc[ACC_W-1:DOT_W-1]) || !(|r_acc[ACC_W-1:DOT_W-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.rd_en;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_base_a <= AW'(AW'(i_item.col_a) * AW'(MAX_RANK));
            r_base_b <= AW'(AW'(i_item.col_b) * AW'(MAX_RANK));
        end
        if (r_rd_vld) begin
            r_prod <= $signed(u_rdata) * $signed(v_rdata);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{(ACC_W-DOT_W){r_prod[DOT_W-1]}}, r_prod};
        end
        if (i_cmd.ld_err) begin
            r_res.dot_product <= '0;
            r_res.saturated   <= 1'b0;
            r_res.index_error <= 1'b1;
        end else if (i_cmd.ld_sum) begin
            r_res.index_error <= 1'b0;
            if (fits) begin
                r_res.dot_product <= r_acc[DOT_W-1:0];
                r_res.saturated   <= 1'b0;
            end else begin
                r_res.dot_product <= r_acc[ACC_W-1] ? DOT_MIN : DOT_MAX;
                r_res.saturated   <= 1'b1;
            end
        end
    end

    assign o_result = r_res;

endmodule

>>> rtl/sampled_column_dot_product_core.sv
`timescale 1ns / 1ps
// Top level of the sampled column dot product core.
//
//  Channel   Ports                          Direction  Handshake
//  -------   -----------------------------  ---------  ----------------------------
//  item      start, i_item                  in         taken when start && !busy
//  result    o_strobe, o_result             out        one cycle, cannot be held off
//  config    i_cfg_we, i_cfg_wdata          in         rank_in_use, written when we
//
// Element writes leave busy low, and the next item may follow at once.
// A query holds busy while it makes one RAM read per element over the single read
// port of each store, for rank elements (rank = rank_in_use clamped to MAX_RANK),
// and while the RAM, multiply and accumulate stages then drain before the clamped
// sum is loaded. The result strobe comes in the first cycle with busy low, so the
// next query can be taken as the strobe comes.
// Index errors give a result in the cycle after the item, with busy staying low.
// i_rst_n is synchronous, active low; it resets control and sets rank_in_use to 32.
// Store contents are not cleared; only written elements may be queried.
module sampled_column_dot_product_core
    import scdp_pkg::*;
#(
    parameter int MAX_RANK    = 32,
    parameter int MAX_COLUMNS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  t_item             i_item,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [RANK_W-1:0] i_cfg_wdata,
    output logic              o_strobe,
    output t_result           o_result
);

    localparam int ROW_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    t_cmd             cmd;
    t_sts             sts;
    logic [ROW_W-1:0] rd_row;

    // sequencing, rank register, busy and result strobe
    scdp_ctrl #(
        .MAX_RANK(MAX_RANK)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_action   (i_item.action),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_row   (rd_row),
        .o_busy     (busy),
        .o_strobe   (o_strobe)
    );

    // stores, multiply-accumulate and result register
    scdp_dp #(
        .MAX_RANK   (MAX_RANK),
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (cmd),
        .i_rd_row(rd_row),
        .o_sts   (sts),
        .o_result(o_result)
    );

endmodule

>>> sim/sampled_column_dot_product_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sampled column dot product core.
module sampled_column_dot_product_core_tb;
    import scdp_pkg::*;

    localparam int ROWS          = 32;
    localparam int COLS          = 1024;
    localparam int ITEM_TARGET   = 1950;
    localparam int SETTLE_CYCLES = 8;
    localparam int N_PHASES      = 10;
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    // Rank per random phase: covers clamping above ROWS, all-ones and the reset value.
    localparam logic [RANK_W-1:0] PHASE_RANKS [N_PHASES] =
        '{6'd32, 6'd1, 6'd63, 6'd17, 6'd45, 6'd8, 6'd32, 6'd24, 6'd2, 6'd40};

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    t_item             i_item      = '0;
    logic              busy;
    logic              i_cfg_we    = 1'b0;
    logic [RANK_W-1:0] i_cfg_wdata = '0;
    logic              o_strobe;
    t_result           o_result;

    // Shadow copy of the factor stores and the rank register.
    logic [ELEM_W-1:0] u_factor [ROWS*COLS];
    logic [ELEM_W-1:0] v_factor [ROWS*COLS];
    logic [RANK_W-1:0] rank_setting = RANK_RESET;
    t_result           expected_dots [$];

    // Stimulus side: which elements have been written so far, and by which columns.
    t_item           pending_items [$];
    logic [ROWS-1:0] u_written [COLS];
    logic [ROWS-1:0] v_written [COLS];
    int              u_cols [$];
    int              v_cols [$];
    int              gen_rank     = ROWS;
    int              items_queued = 0;

    int gap_left     = 0;
    int calm_left    = 0;
    int items_taken  = 0;
    int dots_checked = 0;
    int sat_seen     = 0;
    int err_count    = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    sampled_column_dot_product_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Exact sum of products in 72 bits, then clamp to signed Q32.32.
    function automatic t_result dot_of_columns(logic [9:0] ca, logic [9:0] cb);
        t_result            r;
        logic signed [71:0] acc;
        logic signed [63:0] prod;
        int                 n;
        int                 k;
        r   = '0;
        acc = '0;
        if (ca >= COLS || cb >= COLS) begin
            r.index_error = 1'b1;
            return r;
        end
        n = (rank_setting > ROWS) ? ROWS : rank_setting;
        for (k = 0; k < n; k++) begin
            prod = $signed(u_factor[ca*ROWS + k]) * $signed(v_factor[cb*ROWS + k]);
            acc  = acc + prod;
        end
        if (acc[71:63] == '0 || acc[71:63] == '1) begin
            r.dot_product = acc[63:0];
        end else if (acc[71]) begin
            r.dot_product = DOT_MIN;
            r.saturated   = 1'b1;
        end else begin
            r.dot_product = DOT_MAX;
            r.saturated   = 1'b1;
        end
        return r;
    endfunction

    task automatic apply_item(t_item it);
        t_result bad_index;
        bad_index             = '0;
        bad_index.index_error = 1'b1;
        case (it.action)
            ACT_WR_U, ACT_WR_V: begin
                if (it.col_a >= COLS || it.element_index >= ROWS) begin
                    expected_dots.push_back(bad_index);
                end else if (it.action == ACT_WR_U) begin
                    u_factor[it.col_a*ROWS + it.element_index] = it.value;
                end else begin
                    v_factor[it.col_a*ROWS + it.element_index] = it.value;
                end
            end
            ACT_QUERY: expected_dots.push_back(dot_of_columns(it.col_a, it.col_b));
            default: ;  // undefined action: ignored by the block
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items, random gaps between them
    // ------------------------------------------------------------------

    // Mostly back to back, a few long pauses, and now and then a calm run with no gaps.
    function automatic int next_gap();
        int pick;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_item(i_item);
                if (i_item.action != ACT_UNDEF) items_taken++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    i_item   <= pending_items.pop_front();
                    start    <= 1'b1;
                    gap_left = next_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each strobe is checked against the oldest expected result
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (o_result.saturated === 1'b1) sat_seen++;
            if (expected_dots.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected result dot=%h sat=%b err=%b", $realtime,
                             o_result.dot_product, o_result.saturated, o_result.index_error);
            end else begin
                want = expected_dots.pop_front();
                dots_checked++;
                if (o_result.dot_product !== want.dot_product ||
                    o_result.saturated   !== want.saturated   ||
                    o_result.index_error !== want.index_error) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: mismatch exp dot=%h sat=%b err=%b, got dot=%h sat=%b err=%b",
                                 $realtime, want.dot_product, want.saturated, want.index_error,
                                 o_result.dot_product, o_result.saturated,
                                 o_result.index_error);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [31:0] rand_value();
        int tiny;
        tiny = $urandom_range(0, 2097152) - 1048576;
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return tiny;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(logic [1:0] act, int ca, int cb, int row, logic [31:0] val);
        t_item it;
        it.action        = act;
        it.col_a         = 10'(ca);
        it.col_b         = 10'(cb);
        it.element_index = 5'(row);
        it.value         = val;
        pending_items.push_back(it);
        if (act != ACT_UNDEF) items_queued++;
        if (act == ACT_WR_U) begin
            if (u_written[ca] == '0) u_cols.push_back(ca);
            u_written[ca][row] = 1'b1;
        end else if (act == ACT_WR_V) begin
            if (v_written[ca] == '0) v_cols.push_back(ca);
            v_written[ca][row] = 1'b1;
        end
    endtask

    // Write whatever is missing among the first n rows, so a query never reads
    // an element that was never written.
    task automatic fill_rows(logic [1:0] act, int col, int n);
        logic [ROWS-1:0] have;
        int              k;
        have = (act == ACT_WR_U) ? u_written[col] : v_written[col];
        for (k = 0; k < n; k++)
            if (!have[k]) push_item(act, col, $urandom_range(0, COLS-1), k, rand_value());
    endtask

    task automatic queue_query();
        int ca;
        int cb;
        ca = $urandom_range(0, COLS-1);
        cb = $urandom_range(0, COLS-1);
        if (u_cols.size() != 0 && $urandom_range(0, 9) != 0)
            ca = u_cols[$urandom_range(0, u_cols.size()-1)];
        if (v_cols.size() != 0 && $urandom_range(0, 9) != 0)
            cb = v_cols[$urandom_range(0, v_cols.size()-1)];
        fill_rows(ACT_WR_U, ca, gen_rank);
        fill_rows(ACT_WR_V, cb, gen_rank);
        push_item(ACT_QUERY, ca, cb, $urandom_range(0, ROWS-1), $urandom);
    endtask

    // A few element writes to one column; about half of the bursts use a column that already holds written elements.
    task automatic queue_write_burst();
        logic [1:0] act;
        int         col;
        int         n;
        int         k;
        act = $urandom_range(0, 1) ? ACT_WR_V : ACT_WR_U;
        col = $urandom_range(0, COLS-1);
        if ($urandom_range(0, 1)) begin
            if (act == ACT_WR_U && u_cols.size() != 0)
                col = u_cols[$urandom_range(0, u_cols.size()-1)];
            else if (act == ACT_WR_V && v_cols.size() != 0)
                col = v_cols[$urandom_range(0, v_cols.size()-1)];
        end
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++)
            push_item(act, col, $urandom_range(0, COLS-1), $urandom_range(0, ROWS-1),
                      rand_value());
    endtask

    task automatic random_phase(int count);
        int stop_at;
        int pick;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_query();
            else if (pick < 93)
                queue_write_burst();
            else
                push_item(ACT_UNDEF, $urandom_range(0, COLS-1), $urandom_range(0, COLS-1),
                          $urandom_range(0, ROWS-1), $urandom);
        end
    endtask

    // Register writes only while the block is idle.
    task automatic write_rank(logic [RANK_W-1:0] r);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        rank_setting = r;
        gen_rank     = (r > ROWS) ? ROWS : r;
        @(negedge i_clk);
    endtask

    // Sampled on the falling edge so driver updates of the same step are settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || busy || expected_dots.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int p;
        int k;
        foreach (u_written[c]) begin
            u_written[c] = '0;
            v_written[c] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, rank 3: both saturation directions, the exact 2^63 boundary,
        // small fractional values, the last row and column, an undefined action.
        write_rank(6'd3);
        for (k = 0; k < 3; k++) begin
            push_item(ACT_WR_U, 0, 0, k, 32'h8000_0000);
            push_item(ACT_WR_V, 1023, 0, k, 32'h8000_0000);
        end
        push_item(ACT_QUERY, 0, 1023, 0, 0);
        for (k = 0; k < 3; k++) push_item(ACT_WR_U, 1, 1023, k, 32'h7FFF_FFFF);
        push_item(ACT_QUERY, 1, 1023, 31, 32'hFFFF_FFFF);
        push_item(ACT_WR_U, 2, 0, 0, 32'h0001_0000);
        push_item(ACT_WR_U, 2, 0, 1, 32'hFFFF_FFFF);
        push_item(ACT_WR_U, 2, 0, 2, 32'h0001_8000);
        push_item(ACT_QUERY, 2, 1023, 0, 0);
        push_item(ACT_WR_U, 3, 0, 0, 32'h8000_0000);
        push_item(ACT_WR_U, 3, 0, 1, 32'h8000_0000);
        push_item(ACT_WR_U, 3, 0, 2, 32'h0000_0000);
        push_item(ACT_QUERY, 3, 1023, 0, 0);     // sum is exactly 2^63: clamps by one
        push_item(ACT_WR_U, 1023, 1023, 31, 32'h7FFF_FFFF);
        push_item(ACT_UNDEF, 1023, 1023, 31, 32'hFFFF_FFFF);
        wait_idle();

        // Rank zero reads nothing, so any column pair is fair game.
        write_rank(6'd0);
        push_item(ACT_QUERY, 1023, 1023, 0, 0);
        push_item(ACT_QUERY, 0, 700, 0, 0);
        wait_idle();

        for (p = 0; p < N_PHASES; p++) begin
            write_rank(PHASE_RANKS[p]);
            random_phase((ITEM_TARGET - items_queued) / (N_PHASES - p));
            wait_idle();
        end
        repeat (2 * ROWS) @(posedge i_clk);

        $display("%0d items taken, %0d results checked (%0d saturated), %0d mismatches",
                 items_taken, dots_checked, sat_seen, err_count);
        $display("ranks 3, 0 and %0d random phases with ranks up to 63", N_PHASES);
        if (err_count == 0 && expected_dots.size() == 0)
            $display("sampled_column_dot_product_core_tb OK");
        else
            $display("sampled_column_dot_product_core_tb NOT OK");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #8000000;
        $display("sampled_column_dot_product_core_tb NOT OK");
        $finish;
    end

endmodule
